[design/rgb_to_hsv_converter_top_defines.svh]
// Assertion macros shared by the RGB to HSV converter RTL
`ifndef RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define RHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/rhc_pkg.sv]
// Types and constants of the RGB to HSV converter
`default_nettype none
package rhc_pkg;
  localparam int CH_BITS    = 8;
  localparam int ALPHA_BITS = 8;
  localparam int HUE_BITS   = 15;
  localparam int QB         = 12;
  localparam int NUMH_BITS  = 20;
  localparam int NUMS_BITS  = 16;
  localparam int HW         = 16;
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = 2;
  localparam int QCNT_BITS  = 3;
  localparam logic signed [HW-1:0] SECTOR    = 16'sd3840;
  localparam logic signed [HW-1:0] FULL_TURN = 16'sd23040;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [NUMH_BITS-1:0]  num_h;
    logic [NUMS_BITS-1:0]  num_s;
    logic [CH_BITS-1:0]    delta;
    logic [CH_BITS-1:0]    mx;
    sector_t               sector;
    logic                  neg;
    logic [ALPHA_BITS-1:0] alpha;
  } work_t;

  typedef struct packed {
    work_t         w;
    logic [QB-1:0] q_h;
    logic [QB-1:0] q_s;
  } stage_t;
endpackage
`default_nettype wire

[design/rhc_ifs.sv]
// Pixel channel interfaces: RGBA in, HSV out
`default_nettype none
interface rhc_rgba_if import rhc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CH_BITS-1:0]    red;
  logic [CH_BITS-1:0]    green;
  logic [CH_BITS-1:0]    blue;
  logic [ALPHA_BITS-1:0] opacity;
  modport source (output valid, red, green, blue, opacity, input ready);
  modport sink   (input valid, red, green, blue, opacity, output ready);
endinterface

interface rhc_hsv_if import rhc_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [HUE_BITS-1:0]   hue;
  logic [CH_BITS-1:0]    saturation;
  logic [CH_BITS-1:0]    brightness;
  logic [ALPHA_BITS-1:0] opacity_out;
  modport source (output valid, hue, saturation, brightness, opacity_out, input ready);
  modport sink   (input valid, hue, saturation, brightness, opacity_out, output ready);
endinterface
`default_nettype wire

[design/rhc_front.sv]
// Front end: max/min, sector choice and dividend setup
`default_nettype none
module rhc_front import rhc_pkg::*; (
  rhc_rgba_if.sink     pixel,
  input  logic         full,
  output logic         push,
  output work_t        item
);
  logic [CH_BITS-1:0] r, g, b, mx, mn, mag;
  logic [CH_BITS:0]   diff;

  always_comb begin
    r = pixel.red;
    g = pixel.green;
    b = pixel.blue;
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    if (r == mx) begin
      item.sector = SEC_RED;
      diff = {1'b0, g} - {1'b0, b};
    end else if (g == mx) begin
      item.sector = SEC_GREEN;
      diff = {1'b0, b} - {1'b0, r};
    end else begin
      item.sector = SEC_BLUE;
      diff = {1'b0, r} - {1'b0, g};
    end
    item.neg   = diff[CH_BITS];
    mag        = diff[CH_BITS] ? CH_BITS'(-diff) : diff[CH_BITS-1:0];
    item.num_h = ({4'b0, mag, 8'b0} << 4) - {4'b0, mag, 8'b0};
    item.delta = mx - mn;
    item.num_s = {item.delta, 8'b0} - {8'b0, item.delta};
    item.mx    = mx;
    item.alpha = pixel.opacity;
  end

  assign pixel.ready = !full;
  assign push        = pixel.valid && !full;
endmodule
`default_nettype wire

[design/rhc_queue.sv]
// Short queue between front end and divider pipeline
`default_nettype none
`include "rgb_to_hsv_converter_top_defines.svh"
module rhc_queue import rhc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t wdata,
  input  logic  pop,
  output work_t rdata,
  output logic  full,
  output logic  empty
);
  work_t                mem [QDEPTH];
  logic [QPTR_BITS-1:0] wptr, rptr;
  logic [QCNT_BITS-1:0] count;

  assign full  = (count == QCNT_BITS'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + QCNT_BITS'(push) - QCNT_BITS'(pop);
    end
  end

  `RHC_ASSERT_NOW(a_no_overflow, push, !full, "push into full queue")
  `RHC_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from empty queue")
  `RHC_ASSERT_NEXT(a_count_grows, push && !pop, !empty, "queue lost a pushed entry")
endmodule
`default_nettype wire

[design/rhc_back.sv]
// Back end: pipelined restoring dividers, hue wrap and output register
`default_nettype none
`include "rgb_to_hsv_converter_top_defines.svh"
module rhc_back import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  work_t     head,
  input  logic      empty,
  output logic      pop,
  rhc_hsv_if.source hsv
);
  stage_t               stg   [QB];
  stage_t               nxt   [QB];
  stage_t               src   [QB];
  logic [NUMH_BITS-1:0] dh    [QB];
  logic [NUMH_BITS-1:0] ds    [QB];
  logic [QB-1:0]        stg_v;
  logic                 adv;

  assign adv = !hsv.valid || hsv.ready;
  assign pop = adv && !empty;

  always_comb begin
    src[0].w   = head;
    src[0].q_h = '0;
    src[0].q_s = '0;
    for (int k = 1; k < QB; k++) src[k] = stg[k-1];
  end

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      dh[k] = {{(NUMH_BITS-CH_BITS){1'b0}}, src[k].w.delta} << (QB - 1 - k);
      ds[k] = {{(NUMH_BITS-CH_BITS){1'b0}}, src[k].w.mx} << (QB - 1 - k);
      nxt[k] = src[k];
      if (src[k].w.num_h >= dh[k]) begin
        nxt[k].w.num_h       = src[k].w.num_h - dh[k];
        nxt[k].q_h[QB-1-k] = 1'b1;
      end
      if ({{(NUMH_BITS-NUMS_BITS){1'b0}}, src[k].w.num_s} >= ds[k]) begin
        nxt[k].w.num_s       = NUMS_BITS'({{(NUMH_BITS-NUMS_BITS){1'b0}}, src[k].w.num_s} - ds[k]);
        nxt[k].q_s[QB-1-k] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < QB; k++) stg[k] <= nxt[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) stg_v <= '0;
    else if (adv) stg_v <= {stg_v[QB-2:0], !empty};
  end

  stage_t                 fin;
  logic signed [HW-1:0]   base, hq, h;

  always_comb begin
    fin = stg[QB-1];
    case (fin.w.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = SECTOR <<< 1;
      SEC_BLUE:  base = SECTOR <<< 2;
      default:   base = '0;
    endcase
    hq = HW'(fin.q_h);
    if (fin.w.neg) begin
      if (fin.w.num_h != '0) hq = hq + 16'sd1;
      h = base - hq;
    end else begin
      h = base + hq;
    end
    if (h < 0) h = h + FULL_TURN;
  end

  always_ff @(posedge clk) begin
    if (rst) hsv.valid <= 1'b0;
    else if (adv) hsv.valid <= stg_v[QB-1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hsv.brightness  <= fin.w.mx;
      hsv.opacity_out <= fin.w.alpha;
      if (fin.w.delta == '0) begin
        hsv.hue        <= '0;
        hsv.saturation <= '0;
      end else begin
        hsv.hue        <= h[HUE_BITS-1:0];
        hsv.saturation <= fin.q_s[CH_BITS-1:0];
      end
    end
  end

  `RHC_ASSERT_NOW(a_hue_range, hsv.valid, hsv.hue < 15'd23040, "hue out of range")
  `RHC_ASSERT_NOW(a_black_gray, hsv.valid && hsv.brightness == '0,
    hsv.hue == '0 && hsv.saturation == '0, "black pixel with color")
  `RHC_ASSERT_NOW(a_hue_sat, hsv.valid && hsv.hue != '0, hsv.saturation != '0,
    "hue without saturation")
endmodule
`default_nettype wire

[design/rgb_to_hsv_converter_top.sv]
// RGB to HSV converter top level
// Throughput: one pixel per cycle; the 12-stage divider pipeline advances
// whenever the output register is empty or taken, and a 4-entry queue
// decouples input from output stalls.
// Reset: synchronous rst clears the queue and all pipeline valid bits.
`default_nettype none
module rgb_to_hsv_converter_top import rhc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rhc_rgba_if.sink  pixel,
  rhc_hsv_if.source hsv
);
  work_t f_item, q_head;
  logic  push, pop, full, empty;

  rhc_front u_front (
    .pixel (pixel),
    .full  (full),
    .push  (push),
    .item  (f_item)
  );

  rhc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (f_item),
    .pop   (pop),
    .rdata (q_head),
    .full  (full),
    .empty (empty)
  );

  rhc_back u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (q_head),
    .empty (empty),
    .pop   (pop),
    .hsv   (hsv)
  );
endmodule
`default_nettype wire

[verif/rgb_to_hsv_converter_top_test.sv]
// Testbench for the RGB to HSV converter: random pixel stream checked against a predictor
`default_nettype none
module rgb_to_hsv_converter_top_test import rhc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0] r, g, b, a;
  } rgba_t;

  typedef struct {
    logic [14:0] hue;
    logic [7:0]  sat, val, alpha;
  } hsv_t;

  localparam int SEC_UNITS   = 3840;
  localparam int TURN_UNITS  = 23040;
  localparam int STALL_LIMIT = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rhc_rgba_if pixel ();
  rhc_hsv_if  hsv ();

  rgb_to_hsv_converter_top u_dut (.clk(clk), .rst(rst), .pixel(pixel), .hsv(hsv));

  always #6 clk = ~clk;

  rgba_t pending_pixels[$];
  hsv_t  expected_hsv[$];
  int    mismatches = 0;
  int    pixels_sent = 0;
  int    results_seen = 0;
  int    idle_cycles = 0;
  bit    long_holdoff = 1'b0;
  bit    timed_out = 1'b0;

  function automatic int floor_div(int num, int den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic hsv_t convert_pixel(rgba_t p);
    hsv_t res;
    int mx, mn, delta, base, diff, h;
    mx = (p.r > p.g) ? p.r : p.g;
    if (p.b > mx) mx = p.b;
    mn = (p.r < p.g) ? p.r : p.g;
    if (p.b < mn) mn = p.b;
    delta = mx - mn;
    res.hue = '0;
    res.sat = '0;
    res.val = mx[7:0];
    res.alpha = p.a;
    if (delta != 0) begin
      res.sat = 8'((255 * delta) / mx);
      if (p.r == mx) begin
        base = 0;
        diff = int'(p.g) - int'(p.b);
      end else if (p.g == mx) begin
        base = 2 * SEC_UNITS;
        diff = int'(p.b) - int'(p.r);
      end else begin
        base = 4 * SEC_UNITS;
        diff = int'(p.r) - int'(p.g);
      end
      h = base + floor_div(SEC_UNITS * diff, delta);
      if (h < 0) h += TURN_UNITS;
      res.hue = 15'(h);
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic void queue_pixel(int r, int g, int b, int a);
    rgba_t p;
    p.r = 8'(r);
    p.g = 8'(g);
    p.b = 8'(b);
    p.a = 8'(a);
    pending_pixels.push_back(p);
  endfunction

  // driver
  int  send_gap = 0;
  bit  burst_mode = 1'b0;
  always @(posedge clk) begin
    if (rst) begin
      pixel.valid <= 1'b0;
      pixel.red <= '0;
      pixel.green <= '0;
      pixel.blue <= '0;
      pixel.opacity <= '0;
    end else begin
      if (pixel.valid && pixel.ready) begin
        expected_hsv.push_back(convert_pixel('{pixel.red, pixel.green, pixel.blue,
                                               pixel.opacity}));
        pixels_sent++;
        send_gap = burst_mode ? 0 : pick_gap();
      end
      if (!pixel.valid || pixel.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          pixel.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          rgba_t p;
          p = pending_pixels.pop_front();
          pixel.valid <= 1'b1;
          pixel.red <= p.r;
          pixel.green <= p.g;
          pixel.blue <= p.b;
          pixel.opacity <= p.a;
        end else begin
          pixel.valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stalls
  int recv_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      hsv.ready <= 1'b0;
    end else begin
      if (hsv.valid && hsv.ready) begin
        if (expected_hsv.size() == 0) begin
          $display("unexpected result: hue %0d", hsv.hue);
          mismatches++;
        end else begin
          hsv_t want;
          want = expected_hsv.pop_front();
          if (hsv.hue !== want.hue) report_mismatch("hue", hsv.hue, want.hue);
          if (hsv.saturation !== want.sat) report_mismatch("saturation", hsv.saturation, want.sat);
          if (hsv.brightness !== want.val) report_mismatch("brightness", hsv.brightness, want.val);
          if (hsv.opacity_out !== want.alpha)
            report_mismatch("opacity", hsv.opacity_out, want.alpha);
        end
        results_seen++;
      end
      if (long_holdoff) begin
        hsv.ready <= 1'b0;
      end else if (burst_mode) begin
        hsv.ready <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        hsv.ready <= 1'b0;
      end else begin
        hsv.ready <= 1'b1;
        recv_gap = pick_gap();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if ((pixel.valid && pixel.ready) || (hsv.valid && hsv.ready) || long_holdoff)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT && !timed_out) begin
        timed_out = 1'b1;
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  initial begin
    int v, w;
    pixel.valid = 1'b0;
    pixel.red = '0;
    pixel.green = '0;
    pixel.blue = '0;
    pixel.opacity = '0;
    hsv.ready = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: gray, extremes, ties, each sector, negative hue wrap
    queue_pixel(0, 0, 0, 0);
    queue_pixel(255, 255, 255, 255);
    queue_pixel(128, 128, 128, 170);
    queue_pixel(255, 0, 0, 85);
    queue_pixel(0, 255, 0, 1);
    queue_pixel(0, 0, 255, 128);
    queue_pixel(255, 0, 1, 0);
    queue_pixel(255, 1, 0, 0);
    queue_pixel(255, 255, 0, 0);
    queue_pixel(0, 255, 255, 0);
    queue_pixel(255, 0, 255, 0);
    queue_pixel(1, 0, 0, 0);
    queue_pixel(0, 1, 1, 0);
    queue_pixel(254, 255, 0, 0);
    queue_pixel(0, 254, 255, 0);
    queue_pixel(255, 254, 253, 127);
    queue_pixel(1, 2, 3, 255);
    queue_pixel(200, 100, 150, 64);
    queue_pixel(85, 170, 255, 32);
    queue_pixel(255, 254, 254, 16);
    wait (pending_pixels.size() == 0);

    // receiver holds off while the sender keeps offering, filling the pipeline
    burst_mode = 1'b1;
    for (int i = 0; i < 60; i++)
      queue_pixel($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                  $urandom_range(0, 255));
    @(posedge clk);
    long_holdoff = 1'b1;
    repeat (200) @(posedge clk);
    long_holdoff = 1'b0;
    wait (pending_pixels.size() == 0);
    burst_mode = 1'b0;

    for (int i = 0; i < 940; i++) begin
      case ($urandom_range(0, 5))
        0: begin
          v = $urandom_range(0, 255);
          queue_pixel(v, v, v, $urandom_range(0, 255));
        end
        1: begin
          v = $urandom_range(0, 255);
          w = $urandom_range(0, 255);
          case ($urandom_range(0, 2))
            0: queue_pixel(v, v, w, $urandom_range(0, 255));
            1: queue_pixel(w, v, v, $urandom_range(0, 255));
            default: queue_pixel(v, w, v, $urandom_range(0, 255));
          endcase
        end
        default: queue_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), $urandom_range(0, 255));
      endcase
    end
    wait (pending_pixels.size() == 0 && !pixel.valid);
    wait (expected_hsv.size() == 0);
    repeat (40) @(posedge clk);

    $display("covered %0d pixels (gray, ties, all hue sectors, wrap) with %0d results checked",
             pixels_sent, results_seen);
    $display("random gaps on both channels plus one long output stall of 200 cycles");
    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire
